/* design/t2bpp_pkg.sv */
// shared types, constants and the shade function of the 2bpp tile encoder
`default_nettype none

package t2bpp_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned TBL_CW      = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PLANE_W     = 64;
  localparam int unsigned TILE_W      = 2 * PLANE_W;
  localparam int unsigned WSUM_W      = 18;

  localparam logic [WSUM_W-1:0] SHADE_STEP = WSUM_W'(64000);
  localparam logic [7:0]        ALPHA_MIN  = 8'd128;

  typedef enum logic [1:0] {
    ST_PIXEL,
    ST_SEARCH,
    ST_EMIT
  } t2bpp_state_e;

  typedef struct packed {
    logic pix_take;
    logic srch_clr;
    logic srch_run;
    logic store;
    logic emit;
  } t2bpp_cmd_t;

  typedef struct packed {
    logic last_pix;
    logic hit;
    logic done;
    logic emit_step;
    logic emit_last;
  } t2bpp_sts_t;

  // weighted luma split into four bands; the sum never exceeds four bands
  function automatic logic [1:0] shade_of(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    logic [WSUM_W-1:0] wsum;
    logic [1:0]        s;
    wsum = WSUM_W'(r) * WSUM_W'(212) + WSUM_W'(g) * WSUM_W'(701)
         + WSUM_W'(b) * WSUM_W'(87);
    if (wsum >= WSUM_W'(3) * SHADE_STEP) begin
      s = 2'd3;
    end else if (wsum >= WSUM_W'(2) * SHADE_STEP) begin
      s = 2'd2;
    end else if (wsum >= SHADE_STEP) begin
      s = 2'd1;
    end else begin
      s = 2'd0;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* design/t2bpp_dp.sv */
// datapath: shade mapping, bit planes, tile table search and byte output register
`default_nettype none

module t2bpp_dp (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_we_i,
  input  wire                     cfg_wdata_i,
  input  wire  [7:0]              red_i,
  input  wire  [7:0]              green_i,
  input  wire  [7:0]              blue_i,
  input  wire  [7:0]              alpha_i,
  input  wire                     inside_image_i,
  input  wire                     out_ready_i,
  input  wire t2bpp_pkg::t2bpp_cmd_t cmd_i,
  output t2bpp_pkg::t2bpp_sts_t   sts_o,
  output logic                    out_valid_o,
  output logic [7:0]              tile_byte_o,
  output logic                    last_byte_o
);
  import t2bpp_pkg::*;

  logic                 cull_q;
  logic [5:0]           pix_cnt_q;
  logic [PLANE_W-1:0]   lo_plane_q, hi_plane_q;
  logic [TILE_W-1:0]    mem_q [TABLE_DEPTH];
  logic [TILE_W-1:0]    rd_data_q;
  logic [TBL_CW-1:0]    stored_q, issue_q;
  logic                 cmp_vld_q;
  logic [3:0]           byte_idx_q;
  logic                 out_valid_q, last_q;
  logic [7:0]           byte_q;

  logic [1:0]           shade;
  logic [5:0]           bitpos;
  logic                 rd_en, full, eq, emit_step;
  logic [PLANE_W-1:0]   sel_plane;

  always_comb begin
    shade = shade_of(red_i, green_i, blue_i);
    if (alpha_i < ALPHA_MIN || !inside_image_i) begin
      shade = 2'd0;
    end
  end

  // leftmost pixel of a row lands in the msb of its byte
  assign bitpos    = {pix_cnt_q[5:3], ~pix_cnt_q[2:0]};
  assign rd_en     = cmd_i.srch_run && (issue_q < stored_q);
  assign full      = (stored_q == TBL_CW'(TABLE_DEPTH));
  assign eq        = (rd_data_q == {hi_plane_q, lo_plane_q});
  assign emit_step = cmd_i.emit && (!out_valid_q || out_ready_i);
  assign sel_plane = byte_idx_q[3] ? hi_plane_q : lo_plane_q;

  always_comb begin
    sts_o.last_pix  = (pix_cnt_q == 6'd63);
    sts_o.hit       = cull_q && cmp_vld_q && eq;
    sts_o.done      = !cull_q || (issue_q == stored_q && !cmp_vld_q);
    sts_o.emit_step = emit_step;
    sts_o.emit_last = (byte_idx_q == 4'd15);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cull_q      <= 1'b1;
      pix_cnt_q   <= '0;
      lo_plane_q  <= '0;
      hi_plane_q  <= '0;
      stored_q    <= '0;
      issue_q     <= '0;
      cmp_vld_q   <= 1'b0;
      byte_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cull_q <= cfg_wdata_i;
      end
      // every position is rewritten once per tile, so no clearing is needed
      if (cmd_i.pix_take) begin
        pix_cnt_q          <= pix_cnt_q + 6'd1;
        lo_plane_q[bitpos] <= shade[0];
        hi_plane_q[bitpos] <= shade[1];
      end
      if (cmd_i.srch_clr) begin
        issue_q   <= '0;
        cmp_vld_q <= 1'b0;
      end else begin
        cmp_vld_q <= rd_en;
        if (rd_en) begin
          issue_q <= issue_q + TBL_CW'(1);
        end
      end
      if (cmd_i.store && !full) begin
        stored_q <= stored_q + TBL_CW'(1);
      end
      if (emit_step) begin
        byte_idx_q  <= byte_idx_q + 4'd1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_step) begin
      byte_q <= sel_plane[{byte_idx_q[2:0], 3'b000} +: 8];
      last_q <= (byte_idx_q == 4'd15);
    end
  end

  // tile table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && !full) begin
      mem_q[stored_q[TBL_AW-1:0]] <= {hi_plane_q, lo_plane_q};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[issue_q[TBL_AW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign tile_byte_o = byte_q;
  assign last_byte_o = last_q;

`ifndef SYNTH
  a_stored_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= TBL_CW'(TABLE_DEPTH))
    else $error("tile count beyond table depth");

  a_store_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store && !full |=> stored_q == $past(stored_q) + TBL_CW'(1))
    else $error("store did not advance tile count");

  a_last_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_q |-> byte_idx_q == 4'd0)
    else $error("byte index not wrapped after last byte");
`endif

endmodule

`default_nettype wire

/* design/t2bpp_ctrl.sv */
// controller: pixel intake, table search and byte emission sequencing
`default_nettype none

module t2bpp_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire t2bpp_pkg::t2bpp_sts_t sts_i,
  output t2bpp_pkg::t2bpp_cmd_t   cmd_o
);
  import t2bpp_pkg::*;

  t2bpp_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_PIXEL: begin
        if (in_valid_i && sts_i.last_pix) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        priority if (sts_i.hit) begin
          state_d = ST_PIXEL;
        end else if (sts_i.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.emit_step && sts_i.emit_last) begin
          state_d = ST_PIXEL;
        end
      end
      default: state_d = ST_PIXEL;
    endcase
  end

  always_comb begin
    in_ready_o     = (state_q == ST_PIXEL);
    cmd_o.pix_take = (state_q == ST_PIXEL) && in_valid_i;
    cmd_o.srch_clr = cmd_o.pix_take && sts_i.last_pix;
    cmd_o.srch_run = (state_q == ST_SEARCH);
    cmd_o.store    = (state_q == ST_SEARCH) && !sts_i.hit && sts_i.done;
    cmd_o.emit     = (state_q == ST_EMIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_PIXEL;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  // a culled tile never reaches emission
  a_hit_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEARCH && sts_i.hit |=> state_q == ST_PIXEL)
    else $error("duplicate tile not dropped");
`endif

endmodule

`default_nettype wire

/* design/tile_2bpp_encode_dedup.sv */
// top level: planar 2bpp tile encoder with duplicate tile culling
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------------------
//   pixel in | in_valid_i / in_ready_o    | red_i green_i blue_i alpha_i inside_image_i
//   byte out | out_valid_o / out_ready_i  | tile_byte_o last_byte_o
//   config   | cfg_we_i                   | cfg_wdata_i (cull duplicates)
//
// pixels transfer one per cycle while in_ready_o is high; 64 make a tile
// after the 64th pixel the search compares each stored tile with the new tile in turn;
//   it compares nothing when the table is empty or culling is off; a duplicate ends it early
// a new tile is then emitted as 16 bytes, low plane first; out_ready_i can stall it
// no pixel is taken during search and emission
// reset empties the tile table by zeroing its count; no clearing pass
`default_nettype none

module tile_2bpp_encode_dedup (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire        cfg_wdata_i,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire  [7:0] red_i,
  input  wire  [7:0] green_i,
  input  wire  [7:0] blue_i,
  input  wire  [7:0] alpha_i,
  input  wire        inside_image_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [7:0] tile_byte_o,
  output logic       last_byte_o
);
  import t2bpp_pkg::*;

  t2bpp_cmd_t cmd;
  t2bpp_sts_t sts;

  t2bpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  t2bpp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .alpha_i        (alpha_i),
    .inside_image_i (inside_image_i),
    .out_ready_i    (out_ready_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .tile_byte_o    (tile_byte_o),
    .last_byte_o    (last_byte_o)
  );

endmodule

`default_nettype wire
